>>> design/w4a8_pkg.sv
// Shared types, codes and constants for the W4A8 dot-product accumulator.
package w4a8_pkg;

  localparam int COLUMNS_DEF = 32;
  localparam int LANES       = 8;
  localparam int BYTES       = 4;
  localparam int NIB_W       = 4;
  localparam int NIB_SHIFT   = 4;
  localparam logic [3:0] NIB_MASK = 4'hf;
  localparam int PROD_W      = 12;

  localparam logic [1:0] OP_MAC   = 2'd0;
  localparam logic [1:0] OP_CLOSE = 2'd1;
  localparam logic [1:0] OP_LOAD  = 2'd2;

  localparam logic [31:0] QUIET_BIT   = 32'h0040_0000;
  localparam logic [31:0] DEFAULT_NAN = 32'hFFC0_0000;
  localparam logic [31:0] INF_BITS    = 32'h7F80_0000;

  typedef struct packed {
    logic [1:0]  op;
    logic [4:0]  column;
    logic [31:0] weight_word;
    logic [31:0] act_lo;
    logic [31:0] act_hi;
    logic [31:0] sum_in;
    logic [31:0] scale_in;
    logic [31:0] scale_wgt;
    logic [31:0] load_value;
  } in_word_t;

  typedef struct packed {
    logic [4:0]  out_column;
    logic [31:0] result_value;
  } out_word_t;

  typedef struct packed {
    logic [31:0] acc;
    logic [31:0] sum_in;
    logic [7:0]  zero_point;
    logic [31:0] scale_in;
    logic [31:0] scale_wgt;
    logic [31:0] running;
  } close_req_t;

  typedef struct packed {
    logic [23:0]        sig;
    logic signed [11:0] ex;
  } unp_t;

  typedef enum logic [1:0] {
    TS_IDLE,
    TS_READ,
    TS_CLOSE,
    TS_OUT
  } top_state_t;

  typedef enum logic [3:0] {
    CL_IDLE,
    CL_ZPMUL,
    CL_SUB,
    CL_MSPEC,
    CL_MMUL,
    CL_FSPEC,
    CL_FMUL,
    CL_CLOAD,
    CL_ALIGN,
    CL_ADD,
    CL_NORM,
    CL_DEN,
    CL_RND,
    CL_DONE
  } close_state_t;

  typedef enum logic [2:0] {
    PH_CONV,
    PH_MUL,
    PH_FPROD,
    PH_FP,
    PH_FC,
    PH_FSUM
  } close_phase_t;

endpackage

>>> design/w4a8_lane.sv
// One product lane: unsigned 4-bit weight times signed 8-bit activation.
module w4a8_lane (
  input  logic [3:0]                        wgt_nib,
  input  logic [7:0]                        act,
  output logic signed [w4a8_pkg::PROD_W-1:0] prod
);
  import w4a8_pkg::*;

  logic signed [PROD_W-1:0] w_ext;
  logic signed [PROD_W-1:0] a_ext;

  assign w_ext = $signed({{(PROD_W-NIB_W){1'b0}}, wgt_nib & NIB_MASK});
  assign a_ext = $signed({{(PROD_W-8){act[7]}}, act});
  assign prod  = PROD_W'(w_ext * a_ext);

endmodule

>>> design/w4a8_merge.sv
// Merge stage: sums the lane products into the column accumulator.
module w4a8_merge (
  input  logic signed [w4a8_pkg::PROD_W-1:0] prods [w4a8_pkg::LANES],
  input  logic [31:0]                        acc,
  output logic [31:0]                        acc_sum
);
  import w4a8_pkg::*;

  localparam int SUM_W = PROD_W + $clog2(LANES);

  logic signed [SUM_W-1:0] pair [LANES/2];
  logic signed [SUM_W-1:0] quad [LANES/4];
  logic signed [SUM_W-1:0] total;

  always_comb begin
    for (int i = 0; i < LANES/2; i++) begin
      pair[i] = SUM_W'(prods[2*i]) + SUM_W'(prods[2*i+1]);
    end
    for (int i = 0; i < LANES/4; i++) begin
      quad[i] = pair[2*i] + pair[2*i+1];
    end
    total = quad[0] + quad[1];
  end

  // wraps modulo 2^32
  assign acc_sum = acc + 32'(total);

endmodule

>>> design/w4a8_close_unit.sv
// Multi-cycle close sequencer: zero-point fix, int-to-float, multiply and fused add.
module w4a8_close_unit (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   start,
  input  w4a8_pkg::close_req_t   req,
  output logic                   done,
  output logic [31:0]            result
);
  import w4a8_pkg::*;

  close_state_t       st_r, st_nxt;
  close_phase_t       ph_r;
  close_req_t         req_r;
  logic [31:0]        zprod_r;
  logic [63:0]        m_r;
  logic signed [11:0] t_r;
  logic               sg_r;
  logic               sub_r;
  logic [31:0]        a_r;
  logic [31:0]        p_r;
  logic [31:0]        res_r;
  logic [63:0]        xp_r;
  logic signed [11:0] tp_r;
  logic signed [11:0] base_r;

  function automatic logic f_nan(input logic [31:0] x);
    return (x[30:0] > INF_BITS[30:0]);
  endfunction

  function automatic logic f_inf(input logic [31:0] x);
    return (x[30:0] == INF_BITS[30:0]);
  endfunction

  function automatic logic f_zero(input logic [31:0] x);
    return (x[30:0] == 31'd0);
  endfunction

  function automatic unp_t unpack(input logic [31:0] x);
    unp_t u;
    if (x[30:23] == 8'd0) begin
      u.sig = {1'b0, x[22:0]};
      u.ex  = -12'sd149;
    end else begin
      u.sig = {1'b1, x[22:0]};
      u.ex  = $signed({4'd0, x[30:23]}) - 12'sd150;
    end
    return u;
  endfunction

  // right shift with lost bits jammed into bit 0
  function automatic logic [63:0] jam_shift(input logic [63:0] m, input logic [7:0] sh);
    logic [63:0] mask;
    logic [63:0] r;
    if (sh >= 8'd64) begin
      r = {63'd0, |m};
    end else begin
      mask = ~(64'hFFFF_FFFF_FFFF_FFFF << sh[5:0]);
      r    = (m >> sh[5:0]) | {63'd0, |(m & mask)};
    end
    return r;
  endfunction

  function automatic logic [7:0] cap_sh(input logic signed [11:0] d);
    return (d > 12'sd64) ? 8'd64 : 8'(d);
  endfunction

  // zero-point correction and magnitude
  logic [31:0] sub_d;
  logic [31:0] mag;
  assign sub_d = req_r.acc - zprod_r;
  assign mag   = sub_d[31] ? (32'd0 - sub_d) : sub_d;

  // normalize step
  logic [63:0]        nrm_m;
  logic signed [11:0] nrm_t;
  always_comb begin
    if (m_r[63:48] == 16'd0) begin
      nrm_m = m_r << 16;
      nrm_t = t_r - 12'sd16;
    end else if (m_r[63:60] == 4'd0) begin
      nrm_m = m_r << 4;
      nrm_t = t_r - 12'sd4;
    end else begin
      nrm_m = m_r << 1;
      nrm_t = t_r - 12'sd1;
    end
  end

  // denormalize amount for results below the normal range
  logic signed [11:0] den_amt;
  assign den_amt = -12'sd126 - t_r;

  // round to nearest even and pack
  logic               inc;
  logic [24:0]        mant25;
  logic signed [11:0] ef;
  logic [31:0]        rnd_bits;
  always_comb begin
    inc    = m_r[39] & (m_r[40] | (|m_r[38:0]));
    mant25 = {1'b0, m_r[63:40]} + {24'd0, inc};
    ef     = t_r + 12'sd127 + (mant25[24] ? 12'sd1 : 12'sd0);
    if (sub_r) begin
      rnd_bits = {sg_r, 7'd0, mant25[23:0]};
    end else if (ef >= 12'sd255) begin
      rnd_bits = {sg_r, INF_BITS[30:0]};
    end else begin
      rnd_bits = {sg_r, ef[7:0], (mant25[24] ? 23'd0 : mant25[22:0])};
    end
  end

  // multiply special cases
  logic [31:0] mb;
  logic        m_sg;
  logic        mul_spec;
  logic [31:0] mul_val;
  assign mb   = req_r.scale_in;
  assign m_sg = a_r[31] ^ mb[31];
  always_comb begin
    mul_spec = 1'b1;
    if (f_nan(a_r)) begin
      mul_val = a_r | QUIET_BIT;
    end else if (f_nan(mb)) begin
      mul_val = mb | QUIET_BIT;
    end else if ((f_inf(a_r) && f_zero(mb)) || (f_zero(a_r) && f_inf(mb))) begin
      mul_val = DEFAULT_NAN;
    end else if (f_inf(a_r) || f_inf(mb)) begin
      mul_val = {m_sg, INF_BITS[30:0]};
    end else if (f_zero(a_r) || f_zero(mb)) begin
      mul_val = {m_sg, 31'd0};
    end else begin
      mul_spec = 1'b0;
      mul_val  = 32'd0;
    end
  end

  // fused multiply-add special cases
  logic [31:0] fb;
  logic [31:0] fc;
  logic        sp;
  logic        sc;
  logic        pinf;
  logic        pzero;
  logic        fma_spec;
  logic [31:0] fma_val;
  assign fb    = req_r.scale_wgt;
  assign fc    = req_r.running;
  assign sp    = p_r[31] ^ fb[31];
  assign sc    = fc[31];
  assign pinf  = f_inf(p_r) || f_inf(fb);
  assign pzero = f_zero(p_r) || f_zero(fb);
  always_comb begin
    fma_spec = 1'b1;
    if (f_nan(p_r)) begin
      fma_val = p_r | QUIET_BIT;
    end else if (f_nan(fb)) begin
      fma_val = fb | QUIET_BIT;
    end else if (f_nan(fc)) begin
      fma_val = fc | QUIET_BIT;
    end else if (pinf && pzero) begin
      fma_val = DEFAULT_NAN;
    end else if (pinf) begin
      fma_val = (f_inf(fc) && (sc != sp)) ? DEFAULT_NAN : {sp, INF_BITS[30:0]};
    end else if (f_inf(fc)) begin
      fma_val = fc;
    end else if (pzero) begin
      if (f_zero(fc)) begin
        fma_val = {sp & sc, 31'd0};
      end else begin
        fma_val = fc;
      end
    end else begin
      fma_spec = 1'b0;
      fma_val  = 32'd0;
    end
  end

  // operand unpacking
  unp_t ua_m, ub_m, ua_f, ub_f, uc_f;
  assign ua_m = unpack(a_r);
  assign ub_m = unpack(mb);
  assign ua_f = unpack(p_r);
  assign ub_f = unpack(fb);
  assign uc_f = unpack(fc);

  // alignment onto a common grid
  logic signed [11:0] tmax;
  logic [63:0]        xc_al;
  logic [63:0]        xp_al;
  assign tmax  = (tp_r > t_r) ? tp_r : t_r;
  assign xp_al = jam_shift(xp_r, cap_sh(tmax - tp_r + 12'sd2));
  assign xc_al = jam_shift(m_r, cap_sh(tmax - t_r + 12'sd2));

  // signed magnitude add
  logic [63:0] sum;
  logic        sr;
  always_comb begin
    if (sp == sc) begin
      sum = xp_r + m_r;
      sr  = sp;
    end else if (xp_r >= m_r) begin
      sum = xp_r - m_r;
      sr  = sp;
    end else begin
      sum = m_r - xp_r;
      sr  = sc;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r <= CL_IDLE;
    end else begin
      st_r <= st_nxt;
    end
  end

  always_comb begin
    st_nxt = st_r;
    unique case (st_r)
      CL_IDLE:  if (start) st_nxt = CL_ZPMUL;
      CL_ZPMUL: st_nxt = CL_SUB;
      CL_SUB:   st_nxt = (mag == 32'd0) ? CL_MSPEC : CL_NORM;
      CL_NORM: begin
        if (m_r[63]) begin
          if (ph_r == PH_FP) begin
            st_nxt = CL_CLOAD;
          end else if (ph_r == PH_FC) begin
            st_nxt = CL_ALIGN;
          end else begin
            st_nxt = CL_DEN;
          end
        end
      end
      CL_DEN: st_nxt = CL_RND;
      CL_RND: begin
        if (ph_r == PH_CONV) begin
          st_nxt = CL_MSPEC;
        end else if (ph_r == PH_MUL) begin
          st_nxt = CL_FSPEC;
        end else begin
          st_nxt = CL_DONE;
        end
      end
      CL_MSPEC: st_nxt = mul_spec ? CL_FSPEC : CL_MMUL;
      CL_MMUL:  st_nxt = CL_NORM;
      CL_FSPEC: st_nxt = fma_spec ? CL_DONE : CL_FMUL;
      CL_FMUL:  st_nxt = CL_NORM;
      CL_CLOAD: st_nxt = CL_NORM;
      CL_ALIGN: st_nxt = CL_ADD;
      CL_ADD:   st_nxt = (sum == 64'd0) ? CL_DONE : CL_NORM;
      CL_DONE:  st_nxt = CL_IDLE;
      default:  st_nxt = CL_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    case (st_r)
      CL_IDLE: begin
        if (start) req_r <= req;
      end
      CL_ZPMUL: zprod_r <= req_r.sum_in * {24'd0, req_r.zero_point};
      CL_SUB: begin
        sg_r <= sub_d[31];
        m_r  <= {mag, 32'd0};
        t_r  <= 12'sd31;
        ph_r <= PH_CONV;
        a_r  <= 32'd0;
      end
      CL_NORM: begin
        if (!m_r[63]) begin
          m_r <= nrm_m;
          t_r <= nrm_t;
        end
      end
      CL_DEN: begin
        if (t_r < -12'sd126) begin
          m_r   <= jam_shift(m_r, cap_sh(den_amt));
          sub_r <= 1'b1;
        end else begin
          sub_r <= 1'b0;
        end
      end
      CL_RND: begin
        if (ph_r == PH_CONV) begin
          a_r <= rnd_bits;
        end else if (ph_r == PH_MUL) begin
          p_r <= rnd_bits;
        end else begin
          res_r <= rnd_bits;
        end
      end
      CL_MSPEC: begin
        if (mul_spec) p_r <= mul_val;
      end
      CL_MMUL: begin
        m_r  <= {48'(ua_m.sig) * 48'(ub_m.sig), 16'd0};
        t_r  <= ua_m.ex + ub_m.ex + 12'sd47;
        sg_r <= m_sg;
        ph_r <= PH_MUL;
      end
      CL_FSPEC: begin
        if (fma_spec) res_r <= fma_val;
      end
      CL_FMUL: begin
        m_r  <= {48'(ua_f.sig) * 48'(ub_f.sig), 16'd0};
        t_r  <= ua_f.ex + ub_f.ex + 12'sd47;
        sg_r <= sp;
        ph_r <= f_zero(fc) ? PH_FPROD : PH_FP;
      end
      CL_CLOAD: begin
        xp_r <= m_r;
        tp_r <= t_r;
        m_r  <= {uc_f.sig, 40'd0};
        t_r  <= uc_f.ex + 12'sd23;
        ph_r <= PH_FC;
      end
      CL_ALIGN: begin
        xp_r   <= xp_al;
        m_r    <= xc_al;
        base_r <= tmax - 12'sd61;
      end
      CL_ADD: begin
        m_r   <= sum;
        t_r   <= base_r + 12'sd63;
        sg_r  <= sr;
        ph_r  <= PH_FSUM;
        res_r <= 32'd0;
      end
      default: ;
    endcase
  end

  assign done   = (st_r == CL_DONE);
  assign result = res_r;

endmodule

>>> design/w4a8_quantized_dot_accumulate.sv
// Top level: W4A8 dot-product accumulator with per-column float results.
//
// Input words arrive on in_valid/in_stall/in_data; a word moves when valid is
// high and stall is low. Op MAC adds eight nibble-by-byte products (eight
// parallel lanes and a merge adder) into the column's 32-bit accumulator.
// Op CLOSE removes the zero-point term, converts to float, scales by scale_in
// and fuse-adds the product with scale_wgt into the column's running result,
// then sends {column, result} out on out_valid/out_stall/out_data.
// Op LOAD presets a running result. Unused ops and columns at or above
// COLUMNS are dropped without effect.
// Flow: one word at a time. MAC and LOAD do a registered memory read, then
// write back. A CLOSE posts its result sooner when a zero, infinity or NaN
// operand settles it, and latest when every step of the shared normalize/round
// sequencer needs long shifts.
// The output register lets the next word enter while a result waits; a new
// close finishing while the receiver stalls holds until the register frees.
// Reset clears zero_point, the accumulators and running results (per-entry
// valid bits) and the output valid; no clearing pass is needed.
// cfg_wr_en writes zero_point from cfg_wr_data; users must do so while idle, unenforced.
module w4a8_quantized_dot_accumulate #(
  parameter int COLUMNS = w4a8_pkg::COLUMNS_DEF
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_stall,
  input  w4a8_pkg::in_word_t  in_data,
  output logic                out_valid,
  input  logic                out_stall,
  output w4a8_pkg::out_word_t out_data,
  input  logic                cfg_wr_en,
  input  logic [7:0]          cfg_wr_data
);
  import w4a8_pkg::*;

  localparam int AW = (COLUMNS > 1) ? $clog2(COLUMNS) : 1;

  top_state_t         st_r, st_nxt;
  in_word_t           item_r;
  logic [AW-1:0]      idx_r;
  logic [7:0]         zp_r;
  logic [COLUMNS-1:0] acc_vld_r;
  logic [COLUMNS-1:0] res_vld_r;
  logic               acc_ok_r;
  logic               res_ok_r;
  logic [31:0]        acc_rd_r;
  logic [31:0]        res_rd_r;
  logic [31:0]        close_res_r;
  logic               out_valid_r;
  out_word_t          out_data_r;

  logic [31:0] acc_mem [COLUMNS];
  logic [31:0] res_mem [COLUMNS];

  logic          accept;
  logic          col_ok;
  logic          op_ok;
  logic [AW-1:0] col_idx;
  logic          out_free;
  logic          post;
  logic          mac_wr;
  logic          load_wr;
  logic [31:0]   acc_eff;
  logic [31:0]   res_eff;
  logic [31:0]   acc_sum;
  logic [31:0]   res_wdata;
  logic          cl_start;
  logic          cl_done;
  logic [31:0]   cl_result;
  close_req_t    cl_req;

  logic signed [PROD_W-1:0] prods [LANES];

  assign in_stall = (st_r != TS_IDLE);
  assign accept   = in_valid && !in_stall;
  assign col_ok   = (32'(in_data.column) < 32'(COLUMNS));
  assign col_idx  = AW'(in_data.column);
  assign out_free = !out_valid_r || !out_stall;
  assign post     = (st_r == TS_OUT) && out_free;
  assign mac_wr   = (st_r == TS_READ) && (item_r.op == OP_MAC);
  assign load_wr  = (st_r == TS_READ) && (item_r.op == OP_LOAD);
  assign cl_start = (st_r == TS_READ) && (item_r.op == OP_CLOSE);
  assign acc_eff  = acc_ok_r ? acc_rd_r : 32'd0;
  assign res_eff  = res_ok_r ? res_rd_r : 32'd0;

  always_comb begin
    unique case (in_data.op)
      OP_MAC, OP_CLOSE, OP_LOAD: op_ok = 1'b1;
      default:                   op_ok = 1'b0;
    endcase
  end

  // product lanes: low nibbles with act_lo, high nibbles with act_hi
  for (genvar j = 0; j < BYTES; j++) begin : g_lanes
    w4a8_lane u_lo (
      .wgt_nib (item_r.weight_word[8*j +: NIB_W]),
      .act     (item_r.act_lo[8*j +: 8]),
      .prod    (prods[j])
    );
    w4a8_lane u_hi (
      .wgt_nib (item_r.weight_word[8*j + NIB_SHIFT +: NIB_W]),
      .act     (item_r.act_hi[8*j +: 8]),
      .prod    (prods[BYTES + j])
    );
  end

  w4a8_merge u_merge (
    .prods   (prods),
    .acc     (acc_eff),
    .acc_sum (acc_sum)
  );

  always_comb begin
    cl_req.acc        = acc_eff;
    cl_req.sum_in     = item_r.sum_in;
    cl_req.zero_point = zp_r;
    cl_req.scale_in   = item_r.scale_in;
    cl_req.scale_wgt  = item_r.scale_wgt;
    cl_req.running    = res_eff;
  end

  w4a8_close_unit u_close (
    .clk    (clk),
    .rst_n  (rst_n),
    .start  (cl_start),
    .req    (cl_req),
    .done   (cl_done),
    .result (cl_result)
  );

  assign res_wdata = load_wr ? item_r.load_value : close_res_r;

  // column stores: one write, one registered read
  always_ff @(posedge clk) begin
    if (mac_wr) acc_mem[idx_r] <= acc_sum;
    if (load_wr || post) res_mem[idx_r] <= res_wdata;
    if (accept) begin
      acc_rd_r <= acc_mem[col_idx];
      res_rd_r <= res_mem[col_idx];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r <= TS_IDLE;
    end else begin
      st_r <= st_nxt;
    end
  end

  always_comb begin
    st_nxt = st_r;
    unique case (st_r)
      TS_IDLE:  if (accept && col_ok && op_ok) st_nxt = TS_READ;
      TS_READ:  st_nxt = (item_r.op == OP_CLOSE) ? TS_CLOSE : TS_IDLE;
      TS_CLOSE: if (cl_done) st_nxt = TS_OUT;
      TS_OUT:   if (out_free) st_nxt = TS_IDLE;
      default:  st_nxt = TS_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      zp_r        <= 8'd0;
      acc_vld_r   <= '0;
      res_vld_r   <= '0;
      acc_ok_r    <= 1'b0;
      res_ok_r    <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (cfg_wr_en) zp_r <= cfg_wr_data;
      if (accept) begin
        acc_ok_r <= acc_vld_r[col_idx];
        res_ok_r <= res_vld_r[col_idx];
      end
      if (mac_wr) acc_vld_r[idx_r] <= 1'b1;
      // drop the accumulator on close
      if (post) acc_vld_r[idx_r] <= 1'b0;
      if (load_wr || post) res_vld_r[idx_r] <= 1'b1;
      if (post) begin
        out_valid_r <= 1'b1;
      end else if (!out_stall) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      item_r <= in_data;
      idx_r  <= col_idx;
    end
    if (cl_done) close_res_r <= cl_result;
    if (post) begin
      out_data_r.out_column   <= item_r.column;
      out_data_r.result_value <= close_res_r;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  a_out_from_close: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid) |-> $past(st_r == TS_OUT))
    else $error("result word posted without a finished close");

  a_done_in_close: assert property (@(posedge clk) disable iff (!rst_n)
    cl_done |-> (st_r == TS_CLOSE))
    else $error("close unit finished outside the close state");

  a_mac_reads: assert property (@(posedge clk) disable iff (!rst_n)
    (accept && col_ok && (in_data.op == OP_MAC)) |=> (st_r == TS_READ))
    else $error("accepted MAC word did not enter the read state");

  a_out_held: assert property (@(posedge clk) disable iff (!rst_n)
    (st_r == TS_OUT) && !out_free |=> (st_r == TS_OUT) && out_valid)
    else $error("pending close result left the output state while blocked");

endmodule

>>> tb/w4a8_quantized_dot_accumulate_tb.sv
// Self-checking testbench for the W4A8 dot-product accumulator with float close path.
module w4a8_quantized_dot_accumulate_tb;
  timeunit 1ns;
  timeprecision 1ps;
  import w4a8_pkg::*;

  localparam int DRAIN_CYCLES = 60;

  logic clk;
  logic rst_n;
  logic in_valid;
  logic in_stall;
  in_word_t in_data;
  logic out_valid;
  logic out_stall;
  out_word_t out_data;
  logic cfg_wr_en;
  logic [7:0] cfg_wr_data;

  in_word_t pending_words[$];
  out_word_t expected_results[$];

  // shadow state of the block
  logic [31:0] acc_shadow[COLUMNS_DEF];
  logic [31:0] running_shadow[COLUMNS_DEF];
  logic [7:0] zp_shadow;

  int send_idle_pct;
  int stall_pct;
  bit hold_sender;
  int fail_count;
  int words_sent;
  int results_seen;
  int closes_sent;

  w4a8_quantized_dot_accumulate dut (
    .clk(clk),
    .rst_n(rst_n),
    .in_valid(in_valid),
    .in_stall(in_stall),
    .in_data(in_data),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .out_data(out_data),
    .cfg_wr_en(cfg_wr_en),
    .cfg_wr_data(cfg_wr_data)
  );

  always begin
    clk = 1'b0;
    #5;
    clk = 1'b1;
    #5;
  end

  function automatic int bit_count_len(logic [63:0] m);
    int n;
    n = 0;
    while (m != 0) begin
      m = m >> 1;
      n++;
    end
    return n;
  endfunction

  function automatic void fp_unpack(input logic [31:0] x, output logic [63:0] sig,
                                    output int ex);
    if (x[30:23] == 8'd0) begin
      sig = {41'd0, x[22:0]};
      ex = -149;
    end else begin
      sig = {40'd0, 1'b1, x[22:0]};
      ex = int'(x[30:23]) - 150;
    end
  endfunction

  // round sign * m * 2^e to binary32, nearest even
  function automatic logic [31:0] fp_round(logic sgn, int e, logic [63:0] m);
    int q;
    int s;
    logic [63:0] mant;
    logic rnd;
    logic stk;
    logic [31:0] bits;
    q = e + bit_count_len(m) - 1 - 23;
    if (q < -149) q = -149;
    s = q - e;
    if (s <= 0) begin
      mant = m << (-s);
    end else begin
      if (s >= 65) begin
        rnd = 1'b0;
        stk = (m != 0);
        mant = 0;
      end else begin
        rnd = m[s-1];
        stk = (m & ((64'd1 << (s - 1)) - 64'd1)) != 0;
        mant = (s < 64) ? (m >> s) : 64'd0;
      end
      if (rnd && (stk || mant[0])) mant = mant + 1;
    end
    if ((mant >> 24) != 0) begin
      mant = mant >> 1;
      q++;
    end
    if (mant >= 64'h80_0000) begin
      if (q + 150 >= 255) return {sgn, INF_BITS[30:0]};
      bits = {1'b0, 8'(q + 150), mant[22:0]};
    end else begin
      bits = mant[31:0];
    end
    return {sgn, bits[30:0]};
  endfunction

  function automatic bit is_nan(logic [31:0] x);
    return x[30:0] > INF_BITS[30:0];
  endfunction

  function automatic bit is_inf(logic [31:0] x);
    return x[30:0] == INF_BITS[30:0];
  endfunction

  function automatic bit is_zero(logic [31:0] x);
    return x[30:0] == 31'd0;
  endfunction

  function automatic logic [31:0] int_to_fp(logic [31:0] u);
    logic [31:0] mag;
    mag = u[31] ? (32'd0 - u) : u;
    if (mag == 0) return 32'd0;
    return fp_round(u[31], 0, {32'd0, mag});
  endfunction

  function automatic logic [31:0] fp_mul(logic [31:0] a, logic [31:0] b);
    logic sg;
    logic [63:0] ma;
    logic [63:0] mb;
    int ea;
    int eb;
    sg = a[31] ^ b[31];
    if (is_nan(a)) return a | QUIET_BIT;
    if (is_nan(b)) return b | QUIET_BIT;
    if ((is_inf(a) && is_zero(b)) || (is_zero(a) && is_inf(b))) return DEFAULT_NAN;
    if (is_inf(a) || is_inf(b)) return {sg, INF_BITS[30:0]};
    if (is_zero(a) || is_zero(b)) return {sg, 31'd0};
    fp_unpack(a, ma, ea);
    fp_unpack(b, mb, eb);
    return fp_round(sg, ea + eb, ma * mb);
  endfunction

  // place m*2^e on grid 2^base, sticky into bit 0
  function automatic logic [63:0] onto_grid(logic [63:0] m, int e, int base);
    int d;
    d = e - base;
    if (d >= 0) return m << d;
    if (-d >= 64) return {63'd0, m != 0};
    return (m >> (-d)) | {63'd0, (m & ((64'd1 << (-d)) - 64'd1)) != 0};
  endfunction

  function automatic logic [31:0] fp_fma(logic [31:0] a, logic [31:0] b, logic [31:0] c);
    logic sp;
    logic sc;
    logic sr;
    bit pinf;
    bit pzero;
    logic [63:0] ma;
    logic [63:0] mb;
    logic [63:0] pm;
    logic [63:0] cm;
    logic [63:0] xp;
    logic [63:0] xc;
    logic [63:0] total;
    int ea;
    int eb;
    int pe;
    int ce;
    int tp;
    int tc;
    int base;
    sp = a[31] ^ b[31];
    sc = c[31];
    if (is_nan(a)) return a | QUIET_BIT;
    if (is_nan(b)) return b | QUIET_BIT;
    if (is_nan(c)) return c | QUIET_BIT;
    pinf = is_inf(a) || is_inf(b);
    pzero = is_zero(a) || is_zero(b);
    if (pinf && pzero) return DEFAULT_NAN;
    if (pinf) begin
      if (is_inf(c) && sc != sp) return DEFAULT_NAN;
      return {sp, INF_BITS[30:0]};
    end
    if (is_inf(c)) return c;
    if (pzero) begin
      if (is_zero(c)) return (sp && sc) ? 32'h8000_0000 : 32'd0;
      return c;
    end
    fp_unpack(a, ma, ea);
    fp_unpack(b, mb, eb);
    pm = ma * mb;
    pe = ea + eb;
    if (is_zero(c)) return fp_round(sp, pe, pm);
    fp_unpack(c, cm, ce);
    tp = pe + bit_count_len(pm) - 1;
    tc = ce + bit_count_len(cm) - 1;
    base = ((tp > tc) ? tp : tc) - 61;
    xp = onto_grid(pm, pe, base);
    xc = onto_grid(cm, ce, base);
    if (sp == sc) begin
      total = xp + xc;
      sr = sp;
    end else if (xp >= xc) begin
      total = xp - xc;
      sr = sp;
    end else begin
      total = xc - xp;
      sr = sc;
    end
    if (total == 0) return 32'd0;
    return fp_round(sr, base, total);
  endfunction

  // apply one accepted word to the shadow state; queue the close result
  function automatic void predict_column_update(in_word_t w);
    logic [31:0] acc;
    logic [31:0] prod;
    logic [31:0] res;
    int lo_w;
    int hi_w;
    int lo_a;
    int hi_a;
    out_word_t r;
    case (w.op)
      OP_MAC: begin
        acc = acc_shadow[w.column];
        for (int j = 0; j < BYTES; j++) begin
          lo_w = int'(w.weight_word[8*j +: 4]);
          hi_w = int'(w.weight_word[8*j+4 +: 4]);
          lo_a = int'($signed(w.act_lo[8*j +: 8]));
          hi_a = int'($signed(w.act_hi[8*j +: 8]));
          acc = acc + 32'(lo_w * lo_a + hi_w * hi_a);
        end
        acc_shadow[w.column] = acc;
      end
      OP_CLOSE: begin
        acc = acc_shadow[w.column] - w.sum_in * {24'd0, zp_shadow};
        prod = fp_mul(int_to_fp(acc), w.scale_in);
        res = fp_fma(prod, w.scale_wgt, running_shadow[w.column]);
        running_shadow[w.column] = res;
        acc_shadow[w.column] = 32'd0;
        r.out_column = w.column;
        r.result_value = res;
        expected_results.push_back(r);
      end
      OP_LOAD: running_shadow[w.column] = w.load_value;
      default: ;
    endcase
  endfunction

  // driver: advance to the next word when the current one moved
  always @(posedge clk) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else begin
      if (in_valid && !in_stall) begin
        predict_column_update(in_data);
        words_sent++;
      end
      if (!in_valid || !in_stall) begin
        if (pending_words.size() > 0 && !hold_sender &&
            $urandom_range(99) >= send_idle_pct) begin
          in_data <= pending_words.pop_front();
          in_valid <= 1'b1;
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  always @(posedge clk) begin
    if (!rst_n) out_stall <= 1'b0;
    else out_stall <= ($urandom_range(99) < stall_pct);
  end

  // monitor
  always @(posedge clk) begin
    out_word_t exp_r;
    if (rst_n && out_valid && !out_stall) begin
      results_seen++;
      if (expected_results.size() == 0) begin
        $error("unexpected result: out_column %0d result_value %08h",
               out_data.out_column, out_data.result_value);
        fail_count++;
      end else begin
        exp_r = expected_results.pop_front();
        if (out_data.out_column !== exp_r.out_column) begin
          $error("out_column expected %0d actual %0d", exp_r.out_column, out_data.out_column);
          fail_count++;
        end
        if (out_data.result_value !== exp_r.result_value) begin
          $error("result_value expected %08h actual %08h",
                 exp_r.result_value, out_data.result_value);
          fail_count++;
        end
      end
    end
  end

  function automatic logic [31:0] pick_float();
    logic s;
    s = 1'($urandom_range(1));
    case ($urandom_range(11))
      0: return {s, 31'd0};
      1: return {s, INF_BITS[30:0]};
      2: return {s, 8'hff, 23'($urandom_range(1, 23'h7f_ffff))};
      3: return {s, 8'h00, 23'($urandom)};
      4: return $urandom;
      5: return {s, 8'($urandom_range(240, 254)), 23'($urandom)};
      6: return {s, 8'($urandom_range(1, 12)), 23'($urandom)};
      default: return {s, 8'($urandom_range(110, 140)), 23'($urandom)};
    endcase
  endfunction

  function automatic in_word_t make_word(logic [1:0] op, logic [4:0] col);
    in_word_t w;
    w.op = op;
    w.column = col;
    w.weight_word = $urandom;
    w.act_lo = $urandom;
    w.act_hi = $urandom;
    w.sum_in = ($urandom_range(1) == 1) ? 32'($urandom_range(0, 4000)) : 32'($urandom);
    w.scale_in = pick_float();
    w.scale_wgt = pick_float();
    w.load_value = pick_float();
    return w;
  endfunction

  task automatic wait_drained();
    wait (pending_words.size() == 0 && !in_valid && expected_results.size() == 0);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic write_zero_point(logic [7:0] v);
    @(posedge clk);
    cfg_wr_en <= 1'b1;
    cfg_wr_data <= v;
    zp_shadow = v;
    @(posedge clk);
    cfg_wr_en <= 1'b0;
  endtask

  task automatic push_word(in_word_t w);
    pending_words.push_back(w);
    if (w.op == OP_CLOSE) closes_sent++;
  endtask

  // mostly MAC runs ending in a close, some loads, some noise
  task automatic push_random_words(int count);
    int n;
    int k;
    logic [4:0] col;
    n = 0;
    while (n < count) begin
      col = 5'($urandom_range(31));
      if ($urandom_range(99) < 80) begin
        if ($urandom_range(99) < 30) begin
          push_word(make_word(OP_LOAD, col));
          n++;
        end
        k = $urandom_range(0, 6);
        repeat (k) push_word(make_word(OP_MAC, col));
        push_word(make_word(OP_CLOSE, col));
        n += k + 1;
      end else begin
        push_word(make_word(2'($urandom_range(3)), col));
        n++;
      end
    end
  endtask

  task automatic run_phase(logic [7:0] zp, int send_pct, int rx_pct, int count);
    wait_drained();
    write_zero_point(zp);
    send_idle_pct = send_pct;
    stall_pct = rx_pct;
    push_random_words(count / 2);
    // hold the sender until every outstanding result is back
    wait (pending_words.size() == 0);
    hold_sender = 1'b1;
    wait (!in_valid && expected_results.size() == 0);
    repeat ($urandom_range(1, 5)) @(posedge clk);
    hold_sender = 1'b0;
    push_random_words(count - count / 2);
  endtask

  task automatic push_directed_words();
    in_word_t w;
    w = make_word(OP_MAC, 5'd31);
    w.weight_word = 32'hffff_ffff;
    w.act_lo = 32'h8080_8080;
    w.act_hi = 32'h8080_8080;
    push_word(w);
    w.act_lo = 32'h7f7f_7f7f;
    w.act_hi = 32'h0000_0000;
    push_word(w);
    w = make_word(OP_CLOSE, 5'd31);
    w.scale_in = 32'h3f80_0000;
    w.scale_wgt = 32'h3f80_0000;
    push_word(w);
    // infinity times zero in the multiply
    w = make_word(OP_LOAD, 5'd0);
    w.load_value = 32'h4000_0000;
    push_word(w);
    w = make_word(OP_CLOSE, 5'd0);
    w.scale_in = 32'h7f80_0000;
    push_word(w);
    // NaN running result propagates quieted
    w = make_word(OP_LOAD, 5'd1);
    w.load_value = 32'h7f80_0001;
    push_word(w);
    w = make_word(OP_CLOSE, 5'd1);
    w.scale_in = 32'h3f80_0000;
    w.scale_wgt = 32'h3f80_0000;
    push_word(w);
    // NaN in scale_in, then in scale_wgt
    w = make_word(OP_CLOSE, 5'd2);
    w.scale_in = 32'hff80_1234;
    push_word(w);
    w = make_word(OP_CLOSE, 5'd2);
    w.scale_in = 32'h3f80_0000;
    w.scale_wgt = 32'h7fa0_0000;
    push_word(w);
    // opposite infinities added
    w = make_word(OP_LOAD, 5'd3);
    w.load_value = 32'hff80_0000;
    push_word(w);
    w = make_word(OP_MAC, 5'd3);
    w.weight_word = 32'h0000_0001;
    w.act_lo = 32'h0000_0005;
    push_word(w);
    w = make_word(OP_CLOSE, 5'd3);
    w.scale_in = 32'h7f80_0000;
    w.scale_wgt = 32'h3f80_0000;
    push_word(w);
    // both addends negative zero
    w = make_word(OP_LOAD, 5'd4);
    w.load_value = 32'h8000_0000;
    push_word(w);
    w = make_word(OP_CLOSE, 5'd4);
    w.scale_in = 32'hbf80_0000;
    w.scale_wgt = 32'h3f80_0000;
    push_word(w);
    // subnormal product, then overflow to infinity
    w = make_word(OP_MAC, 5'd5);
    push_word(w);
    w = make_word(OP_CLOSE, 5'd5);
    w.scale_in = 32'h0000_0003;
    w.scale_wgt = 32'h0080_0001;
    push_word(w);
    w = make_word(OP_MAC, 5'd6);
    push_word(w);
    w = make_word(OP_CLOSE, 5'd6);
    w.scale_in = 32'h7f7f_ffff;
    w.scale_wgt = 32'h7f7f_ffff;
    push_word(w);
    // unused op code leaves column 6 untouched
    w = make_word(2'd3, 5'd6);
    push_word(w);
    w = make_word(OP_CLOSE, 5'd6);
    w.scale_in = 32'h3f80_0000;
    push_word(w);
  endtask

  initial begin
    for (int i = 0; i < COLUMNS_DEF; i++) begin
      acc_shadow[i] = 32'd0;
      running_shadow[i] = 32'd0;
    end
    zp_shadow = 8'd0;
    send_idle_pct = 0;
    stall_pct = 0;
    hold_sender = 1'b0;
    fail_count = 0;
    words_sent = 0;
    results_seen = 0;
    closes_sent = 0;
    rst_n = 1'b0;
    in_valid = 1'b0;
    in_data = '0;
    out_stall = 1'b0;
    cfg_wr_en = 1'b0;
    cfg_wr_data = 8'd0;
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;

    push_directed_words();
    run_phase(8'd255, 0, 0, 170);
    run_phase(8'd1, 79, 0, 170);
    run_phase(8'd128, 0, 79, 170);
    run_phase(8'($urandom_range(2, 254)), 37, 37, 170);
    run_phase(8'd0, 0, 0, 170);
    wait_drained();

    $display("Sent %0d words (%0d closes), checked %0d results over five zero-point settings",
             words_sent, closes_sent, results_seen);
    $display("and idle mixes from none to 79%% sender gaps and receiver stalls.");
    if (fail_count == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

  initial begin
    #20ms;
    $display("Timed out with %0d results outstanding", expected_results.size());
    $display("Regression FAIL");
    $finish;
  end

endmodule

>>> w4a8_quantized_dot_accumulate.f
design/w4a8_pkg.sv
design/w4a8_lane.sv
design/w4a8_merge.sv
design/w4a8_close_unit.sv
design/w4a8_quantized_dot_accumulate.sv
tb/w4a8_quantized_dot_accumulate_tb.sv
